/* hw/rtl/sha256_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load_byte;   // write in_byte at fill position
    logic [7:0] in_byte;
    logic       count_byte;  // advance message byte count
    logic       start_block; // copy chain into working vars
    logic       do_round;
    logic       add_chain;
    logic       clear_msg;   // reset chain and counters for next message
  } cmd_t;

  typedef struct packed {
    logic [5:0]  fill_pos;
    logic [63:0] bit_len;
  } status_t;

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LengthPos = 6'd56;
  localparam logic [60:0] CountMax = {61{1'b1}};

  localparam logic [31:0] InitChain [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/sha256_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module sha256_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sha256_pkg::cmd_t    cmd,
  input  wire logic [5:0]          round,
  input  wire logic [2:0]          out_sel,
  output sha256_pkg::status_t      status,
  output logic [31:0]              chain_word,
  output logic                     overflow
);

  logic [31:0] chain [8];
  logic [31:0] win [16];
  logic [31:0] v [8];
  logic [60:0] count;
  logic        ovf;
  logic [5:0]  fill;

  logic [31:0] x15, x2, sg0, sg1, wsch, w, s1, ch, s0, mj, t1, t2;
  logic [1:0]  bsel;
  logic [3:0]  widx;

  always_comb begin
    x15 = win[4'(round + 6'd1)];
    x2 = win[4'(round + 6'd14)];
    sg0 = sha256_pkg::rotr(x15, 7) ^ sha256_pkg::rotr(x15, 18) ^ (x15 >> 3);
    sg1 = sha256_pkg::rotr(x2, 17) ^ sha256_pkg::rotr(x2, 19) ^ (x2 >> 10);
    wsch = win[round[3:0]] + sg0 + win[4'(round + 6'd9)] + sg1;
    w = (round < 6'd16) ? win[round[3:0]] : wsch;
    s1 = sha256_pkg::rotr(v[4], 6) ^ sha256_pkg::rotr(v[4], 11) ^ sha256_pkg::rotr(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + s1 + ch + sha256_pkg::RoundK[round] + w;
    s0 = sha256_pkg::rotr(v[0], 2) ^ sha256_pkg::rotr(v[0], 13) ^ sha256_pkg::rotr(v[0], 22);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = s0 + mj;
    widx = fill[5:2];
    bsel = fill[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_msg) begin
      for (int i = 0; i < 8; i++) chain[i] <= sha256_pkg::InitChain[i];
      count <= '0;
      ovf <= 1'b0;
      fill <= '0;
    end else begin
      if (cmd.load_byte) begin
        unique case (bsel)
          2'd0: win[widx][31:24] <= cmd.in_byte;
          2'd1: win[widx][23:16] <= cmd.in_byte;
          2'd2: win[widx][15:8] <= cmd.in_byte;
          default: win[widx][7:0] <= cmd.in_byte;
        endcase
        fill <= fill + 6'd1;
      end
      if (cmd.count_byte) begin
        if (count != sha256_pkg::CountMax) count <= count + 61'd1;
        else ovf <= 1'b1;
      end
      if (cmd.do_round && round >= 6'd16) win[round[3:0]] <= wsch;
      if (cmd.add_chain) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
      end
    end
  end

  // working variables carry no reset
  always_ff @(posedge clk) begin
    if (cmd.start_block) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
    end else if (cmd.do_round) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  assign status.fill_pos = fill;
  assign status.bit_len = {count, 3'b000};
  assign chain_word = chain[out_sel];
  assign overflow = ovf;

endmodule
`default_nettype wire

/* hw/rtl/sha256_control.sv */
`timescale 1ns / 1ps
`default_nettype none
module sha256_control (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_valid,
  input  wire logic [7:0]           s_byte,
  input  wire logic                 s_has,
  input  wire logic                 s_end,
  output logic                      s_ready,
  output logic                      m_valid,
  input  wire logic                 m_ready,
  input  wire sha256_pkg::status_t  status,
  output sha256_pkg::cmd_t          cmd,
  output logic [5:0]                round,
  output logic [2:0]                out_sel
);

  sha256_pkg::state_t state, state_next;
  sha256_pkg::state_t resume, resume_next;
  logic [6:0] rcnt;
  logic       take, last_fill;
  logic [7:0] pad_byte;
  logic [5:0] lpos;
  logic [2:0] lsh;
  // pad_started marks that 0x80 is already in
  logic       pad_started, pad_started_next;
  // length bytes go in only once the mark left room for them or the block wrapped
  logic       len_ok, len_ok_next;
  // a block compressed after length bytes ends the message
  logic       len_done, len_done_next;

  assign round = rcnt[5:0];
  assign take = s_valid && s_ready;
  assign last_fill = status.fill_pos == 6'd63;

  always_comb begin
    lpos = status.fill_pos - sha256_pkg::LengthPos;
    lsh = 3'd7 - lpos[2:0];
    if (len_ok && status.fill_pos >= sha256_pkg::LengthPos)
      pad_byte = status.bit_len[{lsh, 3'b000} +: 8];
    else
      pad_byte = 8'h00;
  end

  always_comb begin
    state_next = state;
    resume_next = resume;
    pad_started_next = pad_started;
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        if (take) begin
          if (s_has && last_fill) begin
            state_next = sha256_pkg::ST_ROUND;
            resume_next = s_end ? sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
          end else if (s_end) begin
            state_next = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        pad_started_next = 1'b1;
        if (last_fill) begin
          state_next = sha256_pkg::ST_ROUND;
          resume_next = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_ROUND: if (rcnt == 7'd63) state_next = sha256_pkg::ST_ADD;
      sha256_pkg::ST_ADD: state_next = len_done ? sha256_pkg::ST_OUT : resume;
      sha256_pkg::ST_OUT: begin
        pad_started_next = 1'b0;
        if (m_ready && out_sel == 3'd7) state_next = sha256_pkg::ST_IDLE;
      end
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    len_ok_next = len_ok;
    if (state == sha256_pkg::ST_PAD &&
        ((!pad_started && status.fill_pos < sha256_pkg::LengthPos) || last_fill))
      len_ok_next = 1'b1;
    if (state == sha256_pkg::ST_OUT) len_ok_next = 1'b0;
  end

  always_comb begin
    len_done_next = len_done;
    if (state == sha256_pkg::ST_PAD && len_ok && last_fill) len_done_next = 1'b1;
    if (state == sha256_pkg::ST_OUT) len_done_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::ST_IDLE;
      resume <= sha256_pkg::ST_IDLE;
      rcnt <= '0;
      out_sel <= '0;
      pad_started <= 1'b0;
      len_ok <= 1'b0;
      len_done <= 1'b0;
    end else begin
      state <= state_next;
      resume <= resume_next;
      pad_started <= pad_started_next;
      len_ok <= len_ok_next;
      len_done <= len_done_next;
      if (state == sha256_pkg::ST_ROUND) rcnt <= rcnt + 7'd1;
      else rcnt <= '0;
      if (state == sha256_pkg::ST_OUT && m_ready) out_sel <= out_sel + 3'd1;
      else if (state != sha256_pkg::ST_OUT) out_sel <= '0;
    end
  end

  always_comb begin
    cmd = '0;
    s_ready = state == sha256_pkg::ST_IDLE;
    m_valid = state == sha256_pkg::ST_OUT;
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        cmd.load_byte = take && s_has;
        cmd.count_byte = take && s_has;
        cmd.in_byte = s_byte;
        cmd.start_block = take && s_has && last_fill;
      end
      sha256_pkg::ST_PAD: begin
        cmd.load_byte = 1'b1;
        // the 0x80 mark is the first pad byte
        cmd.in_byte = pad_started ? pad_byte : sha256_pkg::PadMark;
        cmd.start_block = last_fill;
      end
      sha256_pkg::ST_ROUND: cmd.do_round = 1'b1;
      sha256_pkg::ST_ADD: cmd.add_chain = 1'b1;
      sha256_pkg::ST_OUT: cmd.clear_msg = m_ready && out_sel == 3'd7;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/sha256_message_digest.sv */
`timescale 1ns / 1ps
`default_nettype none
// Byte-stream SHA-256. Each transaction on the input carries one message byte
// and/or an end mark; bytes are taken back to back while idle, and every 64th
// byte starts a compression (one round per cycle on a single round unit),
// followed by a step that folds the result into the chaining value. An end
// mark pads one byte per cycle outside compression (at most 64 bytes when the
// length fits in the current block, at most 72 when it spills into a second
// one), each full block being compressed in turn, and then returns the eight
// digest words, word 0 first, with tlast on word 7. Input is held off during
// compression, padding and output.
module sha256_message_digest (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // data_byte[7:0], has_byte[8], zero fill
  input  wire logic        s_tlast,  // end_of_message
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // digest_word[31:0], word_index[34:32], zero fill
  output logic             m_tlast,  // last_word
  output logic             m_tuser   // length_overflow
);

  sha256_pkg::cmd_t    cmd;
  sha256_pkg::status_t status;
  logic [5:0]  round;
  logic [2:0]  out_sel;
  logic [31:0] chain_word;
  logic        overflow;

  sha256_control u_ctrl (
    .clk, .rst,
    .s_valid(s_tvalid), .s_byte(s_tdata[7:0]), .s_has(s_tdata[8]), .s_end(s_tlast),
    .s_ready(s_tready), .m_valid(m_tvalid), .m_ready(m_tready),
    .status, .cmd, .round, .out_sel
  );

  sha256_datapath u_dp (
    .clk, .rst, .cmd, .round, .out_sel, .status, .chain_word, .overflow
  );

  assign m_tdata = {5'd0, out_sel, chain_word};
  assign m_tlast = out_sel == 3'd7;
  assign m_tuser = overflow;

  a_no_both: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input and output active together");
  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready)
    else $error("no return to idle after digest");

endmodule
`default_nettype wire
